FILE: rtl/policy_rule_table_match_defines.svh
//============================================================================
// Policy rule table match: assertion macros
// Shared property macros for the concurrent checks in the RTL.
//============================================================================
`ifndef POLICY_RULE_TABLE_MATCH_DEFINES_SVH
`define POLICY_RULE_TABLE_MATCH_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define PRTM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define PRTM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/prtm_pkg.sv
//============================================================================
// prtm_pkg
// Types, field offsets and helpers shared by the rule table match block.
//============================================================================
package prtm_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH         = 2;

    // Field widths of one input item.
    localparam int INDEX_W = 5;
    localparam int ADDR_W  = 32;
    localparam int TOS_W   = 8;
    localparam int TBL_W   = 32;

    // Bit offsets of the input fields inside s_tdata.
    localparam int OFS_INDEX   = 0;
    localparam int OFS_ENABLE  = OFS_INDEX + INDEX_W;
    localparam int OFS_RDST    = OFS_ENABLE + 1;
    localparam int OFS_RSRC    = OFS_RDST + ADDR_W;
    localparam int OFS_RTOS    = OFS_RSRC + ADDR_W;
    localparam int OFS_RTABLE  = OFS_RTOS + TOS_W;
    localparam int OFS_IFACE   = OFS_RTABLE + TBL_W;
    localparam int OFS_KDST    = OFS_IFACE + 1;
    localparam int OFS_KSRC    = OFS_KDST + ADDR_W;
    localparam int OFS_KTOS    = OFS_KSRC + ADDR_W;
    localparam int S_FIELDS_W  = OFS_KTOS + TOS_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } prtm_func_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } prtm_bk_state_t;

    // Status the front end needs before it may change the table.
    typedef struct packed {
        logic q_empty;
        logic back_idle;
    } prtm_drain_t;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: rtl/prtm_ram.sv
//============================================================================
// prtm_ram
// Generic single-write, single-read RAM with a registered read port.
//============================================================================
module prtm_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 32,
    localparam int AW    = prtm_pkg::idx_width(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

FILE: rtl/prtm_front.sv
//============================================================================
// prtm_front
// Input stage: holds one item, writes rules and matches lookup keys.
//============================================================================
module prtm_front #(
    parameter int  DEPTH = prtm_pkg::TABLE_DEPTH_DEFAULT,
    localparam int IDX_W = prtm_pkg::idx_width(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [prtm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  prtm_pkg::prtm_drain_t         drain,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [DEPTH-1:0]              q_vec,
    output logic                          tbl_we,
    output logic [IDX_W-1:0]              tbl_waddr,
    output logic [prtm_pkg::TBL_W-1:0]    tbl_wdata
);

    logic                          stg_valid_reg, stg_valid_next;
    prtm_pkg::prtm_func_t          stg_func_reg;
    logic [prtm_pkg::S_TDATA_W-1:0] stg_data_reg;

    logic [prtm_pkg::INDEX_W-1:0] f_index;
    logic                         f_enable;
    logic [prtm_pkg::ADDR_W-1:0]  f_rdst, f_rsrc, f_kdst, f_ksrc;
    logic [prtm_pkg::TOS_W-1:0]   f_rtos, f_ktos;
    logic                         f_iface;
    logic                         wr_go, lk_go, in_range, accept;

    logic                        valid_reg [DEPTH];
    logic [prtm_pkg::ADDR_W-1:0] dst_reg   [DEPTH];
    logic [prtm_pkg::ADDR_W-1:0] src_reg   [DEPTH];
    logic [prtm_pkg::TOS_W-1:0]  tos_reg   [DEPTH];
    logic                        iface_reg [DEPTH];

    assign f_index  = stg_data_reg[prtm_pkg::OFS_INDEX  +: prtm_pkg::INDEX_W];
    assign f_enable = stg_data_reg[prtm_pkg::OFS_ENABLE];
    assign f_rdst   = stg_data_reg[prtm_pkg::OFS_RDST   +: prtm_pkg::ADDR_W];
    assign f_rsrc   = stg_data_reg[prtm_pkg::OFS_RSRC   +: prtm_pkg::ADDR_W];
    assign f_rtos   = stg_data_reg[prtm_pkg::OFS_RTOS   +: prtm_pkg::TOS_W];
    assign f_iface  = stg_data_reg[prtm_pkg::OFS_IFACE];
    assign f_kdst   = stg_data_reg[prtm_pkg::OFS_KDST   +: prtm_pkg::ADDR_W];
    assign f_ksrc   = stg_data_reg[prtm_pkg::OFS_KSRC   +: prtm_pkg::ADDR_W];
    assign f_ktos   = stg_data_reg[prtm_pkg::OFS_KTOS   +: prtm_pkg::TOS_W];

    // A write waits until every queued lookup has read its table ids.
    assign wr_go    = stg_valid_reg && (stg_func_reg == prtm_pkg::FUNC_WRITE)
                      && drain.q_empty && drain.back_idle;
    assign lk_go    = stg_valid_reg && (stg_func_reg == prtm_pkg::FUNC_LOOKUP) && !q_full;
    assign in_range = 32'(f_index) < 32'(DEPTH);
    assign s_tready = !stg_valid_reg || wr_go || lk_go;
    assign accept   = s_tvalid && s_tready;

    assign tbl_we    = wr_go && in_range;
    assign tbl_waddr = IDX_W'(f_index);
    assign tbl_wdata = stg_data_reg[prtm_pkg::OFS_RTABLE +: prtm_pkg::TBL_W];

    assign q_push = lk_go;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            q_vec[i] = valid_reg[i] && !iface_reg[i]
                       && ((dst_reg[i] == '0) || (dst_reg[i] == f_kdst))
                       && ((src_reg[i] == '0) || (src_reg[i] == f_ksrc))
                       && ((tos_reg[i] == '0) || (tos_reg[i] == f_ktos));
        end
    end

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (accept) begin
            stg_valid_next = 1'b1;
        end else if (wr_go || lk_go) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_func_reg <= prtm_pkg::prtm_func_t'(s_tuser);
            stg_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_we && (tbl_waddr == IDX_W'(i))) begin
                    valid_reg[i] <= f_enable;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_we && (tbl_waddr == IDX_W'(i))) begin
                dst_reg[i]   <= f_rdst;
                src_reg[i]   <= f_rsrc;
                tos_reg[i]   <= f_rtos;
                iface_reg[i] <= f_iface;
            end
        end
    end

endmodule

FILE: rtl/prtm_fifo.sv
//============================================================================
// prtm_fifo
// Short queue of match vectors between the front and back ends.
//============================================================================
module prtm_fifo #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = prtm_pkg::QUEUE_DEPTH,
    localparam int PW    = prtm_pkg::idx_width(DEPTH),
    localparam int CW    = prtm_pkg::idx_width(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/prtm_back.sv
//============================================================================
// prtm_back
// Result engine: walks a match vector, one id per match or a not-found beat.
//============================================================================
module prtm_back #(
    parameter int  DEPTH = prtm_pkg::TABLE_DEPTH_DEFAULT,
    localparam int IDX_W = prtm_pkg::idx_width(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  logic [DEPTH-1:0]           q_vec,
    output logic                       q_pop,
    output logic                       rd_en,
    output logic [IDX_W-1:0]           rd_addr,
    input  logic [prtm_pkg::TBL_W-1:0] rd_data,
    output logic                       back_idle,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [prtm_pkg::TBL_W-1:0] m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    prtm_pkg::prtm_bk_state_t state_reg, state_next;
    logic [DEPTH-1:0] vec_reg, vec_next, vec_rest;
    logic [IDX_W-1:0] low_idx;

    // Pending stage: a beat whose table id sits in the RAM read register.
    logic pend_valid_reg, pend_valid_next;
    logic pend_found_reg, pend_found_next;
    logic pend_last_reg,  pend_last_next;
    logic pend_set, pend_free, out_load;

    logic                       out_valid_reg, out_valid_next;
    logic [prtm_pkg::TBL_W-1:0] out_data_reg;
    logic                       out_user_reg, out_last_reg;

    assign out_load  = pend_valid_reg && (!out_valid_reg || m_tready);
    assign pend_free = !pend_valid_reg || out_load;
    assign vec_rest  = vec_reg & (vec_reg - DEPTH'(1));

    always_comb begin
        low_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (vec_reg[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    // Next state and vector.
    always_comb begin
        state_next = state_reg;
        vec_next   = vec_reg;
        case (state_reg)
            prtm_pkg::BK_IDLE: begin
                if (q_pop && (q_vec != '0)) begin
                    state_next = prtm_pkg::BK_SCAN;
                    vec_next   = q_vec;
                end
            end
            prtm_pkg::BK_SCAN: begin
                if (rd_en) begin
                    vec_next = vec_rest;
                    if (vec_rest == '0) begin
                        state_next = prtm_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = prtm_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        pend_set        = 1'b0;
        pend_found_next = pend_found_reg;
        pend_last_next  = pend_last_reg;
        case (state_reg)
            prtm_pkg::BK_IDLE: begin
                q_pop = !q_empty && pend_free;
                if (q_pop && (q_vec == '0)) begin
                    pend_set        = 1'b1;
                    pend_found_next = 1'b0;
                    pend_last_next  = 1'b1;
                end
            end
            prtm_pkg::BK_SCAN: begin
                rd_en = pend_free;
                if (rd_en) begin
                    pend_set        = 1'b1;
                    pend_found_next = 1'b1;
                    pend_last_next  = vec_rest == '0;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign rd_addr         = low_idx;
    assign back_idle       = state_reg == prtm_pkg::BK_IDLE;
    assign pend_valid_next = pend_set || (pend_valid_reg && !out_load);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= prtm_pkg::BK_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vec_reg        <= vec_next;
        pend_found_reg <= pend_found_next;
        pend_last_reg  <= pend_last_next;
        if (out_load) begin
            out_data_reg <= pend_found_reg ? rd_data : '0;
            out_user_reg <= pend_found_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/policy_rule_table_match.sv
//============================================================================
// policy_rule_table_match
// IPv4 policy rule table, wildcard lookup, a result beat per match or a not-found one.
//============================================================================
//
//  Channel | Direction | Signals                          | Contents
//  --------+-----------+----------------------------------+-----------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | rule write or lookup key
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser | table id, found flag, last
//          |           | m_tlast                          |
//
//  A lookup passes through the input stage and the queue, and the result
//  engine then reads the id of each matching rule in turn; a lookup with
//  no match yields a single not-found beat instead.
//  A write completes once the queue and result engine have
//  drained, since queued lookups still read table ids from the id RAM.
//  Reset clears the rule valid bits at once; there is no clearing pass.
//  Either side may stall independently: the queue and the output register
//  decouple the input stage from the result beats.
//
`include "policy_rule_table_match_defines.svh"

module policy_rule_table_match #(
    parameter int TABLE_DEPTH = prtm_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, from bit 0: rule_index[4:0], rule_enable, rule_dst[31:0],
    // rule_src[31:0], rule_tos[7:0], rule_table[31:0], rule_iface_named,
    // key_dst[31:0], key_src[31:0], key_tos[7:0], one zero pad bit.
    input  logic [prtm_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func (0 = write rule, 1 = look up key).
    input  logic                           s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: out_table_id[31:0].
    output logic [prtm_pkg::TBL_W-1:0]     m_tdata,
    // m_tuser: found.
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int IDX_W = prtm_pkg::idx_width(TABLE_DEPTH);

    prtm_pkg::prtm_drain_t      drain;
    logic                       q_push, q_pop, q_full, q_empty;
    logic [TABLE_DEPTH-1:0]     push_vec, q_vec;
    logic                       tbl_we, rd_en, back_idle;
    logic [IDX_W-1:0]           tbl_waddr, rd_addr;
    logic [prtm_pkg::TBL_W-1:0] tbl_wdata, rd_data;

    assign drain.q_empty   = q_empty;
    assign drain.back_idle = back_idle;

    // The input stage holds one item; it owns the per-rule compare fields.
    prtm_front #(
        .DEPTH (TABLE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .drain     (drain),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_vec     (push_vec),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata)
    );

    // Match vectors wait here until the result engine picks them up.
    prtm_fifo #(
        .WIDTH (TABLE_DEPTH),
        .DEPTH (prtm_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_vec),
        .pop       (q_pop),
        .pop_data  (q_vec),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Table ids live in a RAM; only the result engine reads them.
    prtm_ram #(
        .WIDTH (prtm_pkg::TBL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_id_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    prtm_back #(
        .DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_vec     (q_vec),
        .q_pop     (q_pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .back_idle (back_idle),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // A not-found beat is always the only and last beat, with a zero id.
    `PRTM_ASSERT_IMP(a_nf_last, m_tvalid && !m_tuser, m_tlast, "not-found beat without last")
    `PRTM_ASSERT_IMP(a_nf_zero, m_tvalid && !m_tuser, m_tdata == '0, "not-found beat nonzero id")
    // The id RAM must not change under a lookup that still reads it.
    `PRTM_ASSERT_IMP(a_wr_drained, tbl_we, q_empty && back_idle, "rule write while busy")
    `PRTM_ASSERT_IMP(a_push_room, q_push, !q_full, "push into a full queue")
    // A popped vector with matches starts a scan on the next cycle.
    `PRTM_ASSERT_NXT(a_pop_scan, q_pop && (q_vec != '0), !back_idle, "scan did not start")

endmodule
